FILE: rtl/mss_pkg.sv
// Package for the merge sort sequence block: default sizes and the command and
// status structs that pass between the controller and the datapath.
// No dependencies.
package mss_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned DepthDef     = 64;
  localparam int unsigned ValueBitsDef = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // store the accepted input element
    logic prime;     // issue the first reads of a pass or of the output run
    logic merge;     // merge one element into the destination store
    logic emit_adv;  // a result transfer completed; step to the next element
  } mss_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic seq_end;    // the input element at the port ends the sequence
    logic sorted;     // the run width covers the whole sequence
    logic pass_done;  // this merge cycle writes the last element of the pass
    logic out_final;  // the element being shown is the last of the run
  } mss_stat_t;

endpackage

FILE: rtl/mss_intf.sv
// Handshake channel interfaces for the merge sort sequence block.
// Depends on nothing; the payload width is a parameter.

// Input channel: one sequence element per transfer.
interface mss_in_if #(
  parameter int unsigned VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic                         is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

// Output channel: one sorted element per transfer.
interface mss_out_if #(
  parameter int unsigned VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] sorted_value;
  logic                         is_final;

  modport source (output valid, output sorted_value, output is_final, input ready);
  modport sink   (input valid, input sorted_value, input is_final, output ready);
endinterface

FILE: rtl/merge_sort_sequence_core.sv
// Top level of the merge sort sequence block: controller, datapath and assertions.
// Depends on mss_pkg, mss_intf, mss_ctrl and mss_datapath.
//
//   Channel  Dir  Payload                       Transfer
//   in_i     in   value, is_last                valid && ready
//   out_o    out  sorted_value, is_final        valid && ready
//
// A sequence of n elements loads at one per cycle while the source offers one, then takes
// ceil(log2 n) merge passes, each a priming step and then one element merged per cycle
// through the single write port of each store, then a final priming step and the output
// run of n results, which stalls whenever the sink holds ready low.
// Input is refused from the end of a sequence until its final result transfers.
// No clearing pass after reset; the stores are never read before they are written.
module merge_sort_sequence_core #(
  parameter int unsigned DEPTH      = mss_pkg::DepthDef,
  parameter int unsigned VALUE_BITS = mss_pkg::ValueBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mss_in_if.sink     in_i,
  mss_out_if.source  out_o
);
  import mss_pkg::*;

  mss_cmd_t  cmd;
  mss_stat_t stat;

  // Sequencing of load, merge passes and output run.
  mss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid)
  );

  // Element stores and merge logic.
  mss_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .value_i        (in_i.value),
    .is_last_i      (in_i.is_last),
    .sorted_value_o (out_o.sorted_value),
    .is_final_o     (out_o.is_final)
  );

`ifndef SYNTHESIS
  // Loading and result output never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while a result is shown");

  // A transfer that ends a sequence stops further input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.is_last) |=> !in_i.ready)
    else $error("input still accepted after the last element");

  // The final result returns the block to loading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.is_final) |=> (in_i.ready && !out_o.valid))
    else $error("block not ready for a new sequence after the final result");

  // A priming cycle is always followed by merging or output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.prime |=> (cmd.merge || out_o.valid))
    else $error("priming cycle not followed by a merge or the output run");
`endif

endmodule

FILE: rtl/mss_ram.sv
// Generic simple dual-port RAM: one write port and two registered read ports.
// No dependencies.
module mss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered reads; a read at the written address sees old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: rtl/mss_ctrl.sv
// Controller of the merge sort sequence block: load, merge passes and output run.
// Depends on mss_pkg.
module mss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  input  mss_pkg::mss_stat_t stat_i,
  output mss_pkg::mss_cmd_t  cmd_o,
  output logic              in_ready_o,
  output logic              out_valid_o
);
  import mss_pkg::*;

  localparam logic [1:0] StLoad  = 2'd0;
  localparam logic [1:0] StPrime = 2'd1;
  localparam logic [1:0] StMerge = 2'd2;
  localparam logic [1:0] StEmit  = 2'd3;

  logic [1:0] state_q, state_d;

  // Handshake and command decode from the current state.
  always_comb begin
    in_ready_o     = (state_q == StLoad);
    out_valid_o    = (state_q == StEmit);
    cmd_o.load     = (state_q == StLoad) && in_valid_i;
    cmd_o.prime    = (state_q == StPrime);
    cmd_o.merge    = (state_q == StMerge);
    cmd_o.emit_adv = (state_q == StEmit) && out_ready_i;
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StLoad: begin
        if (in_valid_i && stat_i.seq_end) begin
          state_d = StPrime;
        end
      end
      StPrime: begin
        state_d = stat_i.sorted ? StEmit : StMerge;
      end
      StMerge: begin
        if (stat_i.pass_done) begin
          state_d = StPrime;
        end
      end
      StEmit: begin
        if (out_ready_i && stat_i.out_final) begin
          state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/mss_datapath.sv
// Datapath of the merge sort sequence block: two element stores used in turn as
// source and destination of the bottom-up merge passes, with run and index counters.
// Depends on mss_pkg and mss_ram.
module mss_datapath #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mss_pkg::mss_cmd_t            cmd_i,
  output mss_pkg::mss_stat_t           stat_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic                         is_last_i,
  output logic signed [VALUE_BITS-1:0] sorted_value_o,
  output logic                         is_final_o
);
  import mss_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = CW + 1;
  localparam int unsigned TW = CW + 2;

  // Element count, run width, store select and merge indices.
  logic [CW-1:0] count_q, count_d;
  logic [WW-1:0] width_q, width_d;
  logic          src_q, src_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, mid_q, mid_d, hi_q, hi_d;

  logic [VALUE_BITS-1:0] a_rd_i, a_rd_j, b_rd_i, b_rd_j;
  logic signed [VALUE_BITS-1:0] head_i, head_j, merged;
  logic          take_left;
  logic [CW-1:0] k_next;
  logic          run_done;
  logic [TW-1:0] sum_mid, sum_hi, n_ext;
  logic [CW-1:0] next_mid, next_hi;
  logic          we_a, we_b;
  logic [AW-1:0] waddr_a;
  logic [VALUE_BITS-1:0] wdata_a;

  // Heads of the two runs, read from the current source store.
  assign head_i = src_q ? $signed(b_rd_i) : $signed(a_rd_i);
  assign head_j = src_q ? $signed(b_rd_j) : $signed(a_rd_j);

  // Left run wins on equal values, which keeps the sort stable.
  assign take_left = (i_q < mid_q) && ((j_q >= hi_q) || (head_i <= head_j));
  assign merged    = take_left ? head_i : head_j;
  assign k_next    = k_q + CW'(1);
  assign run_done  = (k_next == hi_q);

  // Bounds of the next run pair, clipped to the sequence length.
  always_comb begin
    n_ext    = TW'(count_q);
    sum_mid  = TW'(hi_q) + TW'(width_q);
    sum_hi   = TW'(hi_q) + TW'({width_q, 1'b0});
    if (cmd_i.prime) begin
      sum_mid = TW'(width_q);
      sum_hi  = TW'({width_q, 1'b0});
    end
    next_mid = (sum_mid >= n_ext) ? count_q : sum_mid[CW-1:0];
    next_hi  = (sum_hi >= n_ext) ? count_q : sum_hi[CW-1:0];
  end

  // Status back to the controller.
  always_comb begin
    stat_o.seq_end   = is_last_i || (count_q == CW'(DEPTH - 1));
    stat_o.sorted    = (width_q >= WW'(count_q));
    stat_o.pass_done = run_done && (hi_q == count_q);
    stat_o.out_final = (i_q == (count_q - CW'(1)));
  end

  assign sorted_value_o = head_i;
  assign is_final_o     = stat_o.out_final;

  // Counter and index updates.
  always_comb begin
    count_d = count_q;
    width_d = width_q;
    src_d   = src_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    if (cmd_i.load) begin
      count_d = count_q + CW'(1);
      if (stat_o.seq_end) begin
        width_d = WW'(1);
        src_d   = 1'b0;
      end
    end
    if (cmd_i.prime) begin
      i_d   = '0;
      k_d   = '0;
      mid_d = next_mid;
      hi_d  = next_hi;
      j_d   = next_mid;
    end
    if (cmd_i.merge) begin
      k_d = k_next;
      if (take_left) begin
        i_d = i_q + CW'(1);
      end else begin
        j_d = j_q + CW'(1);
      end
      if (run_done) begin
        if (hi_q == count_q) begin
          // End of pass: double the run width and swap the stores.
          width_d = {width_q[WW-2:0], 1'b0};
          src_d   = ~src_q;
        end else begin
          i_d   = hi_q;
          mid_d = next_mid;
          hi_d  = next_hi;
          j_d   = next_mid;
        end
      end
    end
    if (cmd_i.emit_adv) begin
      if (stat_o.out_final) begin
        count_d = '0;
      end else begin
        i_d = i_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      width_q <= '0;
      src_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
    end else begin
      count_q <= count_d;
      width_q <= width_d;
      src_q   <= src_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
    end
  end

  // Store A takes loaded elements and the second, fourth and later even passes;
  // store B takes the first pass and the other odd ones.
  assign we_a    = cmd_i.load || (cmd_i.merge && src_q);
  assign we_b    = cmd_i.merge && !src_q;
  assign waddr_a = cmd_i.load ? count_q[AW-1:0] : k_q[AW-1:0];
  assign wdata_a = cmd_i.load ? value_i : merged;

  mss_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store_a (
    .clk_i     (clk_i),
    .we_i      (we_a),
    .waddr_i   (waddr_a),
    .wdata_i   (wdata_a),
    .raddr_a_i (i_d[AW-1:0]),
    .raddr_b_i (j_d[AW-1:0]),
    .rdata_a_o (a_rd_i),
    .rdata_b_o (a_rd_j)
  );

  mss_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store_b (
    .clk_i     (clk_i),
    .we_i      (we_b),
    .waddr_i   (k_q[AW-1:0]),
    .wdata_i   (merged),
    .raddr_a_i (i_d[AW-1:0]),
    .raddr_b_i (j_d[AW-1:0]),
    .rdata_a_o (b_rd_i),
    .rdata_b_o (b_rd_j)
  );

endmodule

FILE: dv/merge_sort_sequence_core_tb.sv
// Self-checking testbench for merge_sort_sequence_core: random and directed sequences,
// each checked against a sorted copy kept by the testbench.
// Depends on mss_pkg, mss_intf and the merge_sort_sequence_core RTL.
module merge_sort_sequence_core_tb;

  localparam int unsigned DEPTH      = mss_pkg::DepthDef;
  localparam int unsigned VALUE_BITS = mss_pkg::ValueBitsDef;

  localparam int unsigned ItemTarget = 450;
  localparam int unsigned HoldAfter  = 100;   // result count that starts the long hold
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned IdleLimit  = 4000;  // cycles without any transfer
  localparam int unsigned TailCycles = 30;
  localparam int unsigned MaxReports = 10;

  localparam logic signed [VALUE_BITS-1:0] MinVal = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] MaxVal = ~MinVal;

  typedef enum int unsigned {ValFull, ValNarrow, ValCorner} val_style_e;

  // One element offered to the block; hold_for_drain makes the sender wait
  // until every expected result has come before offering it.
  typedef struct {
    logic signed [VALUE_BITS-1:0] value;
    logic                         is_last;
    bit                           hold_for_drain;
  } seq_elem_t;

  typedef struct {
    logic signed [VALUE_BITS-1:0] value;
    logic                         is_final;
  } sorted_elem_t;

  logic clk_i;
  logic rst_ni;

  mss_in_if  #(.VALUE_BITS(VALUE_BITS)) seq_in ();
  mss_out_if #(.VALUE_BITS(VALUE_BITS)) sorted_out ();

  merge_sort_sequence_core #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (seq_in.sink),
    .out_o  (sorted_out.source)
  );

  seq_elem_t    item_queue[$];
  sorted_elem_t expected_run[$];

  // Sequence being gathered by the predictor.
  logic signed [VALUE_BITS-1:0] gather_buf[DEPTH];
  int unsigned                  gather_len = 0;

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;
  int unsigned send_gap     = 0;
  int unsigned send_quiet   = 0;
  int unsigned recv_stall   = 0;
  int unsigned recv_quiet   = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  // Clock, reset and known values on every block input from time zero.
  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    seq_in.valid     = 1'b0;
    seq_in.value     = '0;
    seq_in.is_last   = 1'b0;
    sorted_out.ready = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("MISMATCH: %s", msg);
    end
  endfunction

  // Random wait before the next transfer, with occasional runs of no waiting.
  function automatic int unsigned draw_wait(inout int unsigned quiet_left);
    if (quiet_left != 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(10, 30);
    end
    return $urandom_range(0, 6);
  endfunction

  // Sorts the gathered sequence ascending (stable) and queues it as one run.
  function automatic void emit_sorted_run();
    logic signed [VALUE_BITS-1:0] key;
    int                           j;
    sorted_elem_t                 res;
    for (int i = 1; i < int'(gather_len); i++) begin
      key = gather_buf[i];
      j   = i;
      while (j > 0 && gather_buf[j-1] > key) begin
        gather_buf[j] = gather_buf[j-1];
        j--;
      end
      gather_buf[j] = key;
    end
    for (int unsigned k = 0; k < gather_len; k++) begin
      res.value    = gather_buf[k];
      res.is_final = (k + 1 == gather_len);
      expected_run.push_back(res);
    end
    gather_len = 0;
  endfunction

  // A sequence ends on the last flag or when the store is full.
  function automatic void gather_element(logic signed [VALUE_BITS-1:0] value, logic is_last);
    gather_buf[gather_len] = value;
    gather_len++;
    if (is_last || gather_len == DEPTH) begin
      emit_sorted_run();
    end
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_value(val_style_e style);
    case (style)
      ValNarrow: return VALUE_BITS'(int'($urandom_range(0, 8)) - 4);
      ValCorner: begin
        case ($urandom_range(0, 4))
          0:       return MinVal;
          1:       return MaxVal;
          2:       return '0;
          3:       return '1;
          default: return VALUE_BITS'(1);
        endcase
      end
      default: return VALUE_BITS'({$urandom(), $urandom()});
    endcase
  endfunction

  task automatic add_item(logic signed [VALUE_BITS-1:0] value, logic is_last,
                          bit hold_for_drain = 1'b0);
    seq_elem_t e;
    e.value          = value;
    e.is_last        = is_last;
    e.hold_for_drain = hold_for_drain;
    item_queue.push_back(e);
  endtask

  task automatic add_sequence(int unsigned len, val_style_e style, bit hold_for_drain);
    for (int unsigned k = 0; k < len; k++) begin
      add_item(pick_value(style), k + 1 == len, hold_for_drain && k == 0);
    end
  endtask

  // Input driver: offers queued elements, waits a drawn gap after each transfer.
  always @(posedge clk_i) begin : driver_p
    seq_elem_t nxt;
    bit        slot_free;
    bit        launch;
    if (!rst_ni) begin
      seq_in.valid   <= 1'b0;
      seq_in.value   <= '0;
      seq_in.is_last <= 1'b0;
    end else begin
      launch    = 1'b0;
      slot_free = !seq_in.valid || seq_in.ready;
      if (seq_in.valid && seq_in.ready) begin
        gather_element(seq_in.value, seq_in.is_last);
        send_gap = draw_wait(send_quiet);
      end
      if (slot_free) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (item_queue.size() != 0 &&
                     (!item_queue[0].hold_for_drain || expected_run.size() == 0)) begin
          launch = 1'b1;
        end
      end
      if (launch) begin
        nxt = item_queue.pop_front();
        seq_in.value   <= nxt.value;
        seq_in.is_last <= nxt.is_last;
        seq_in.valid   <= 1'b1;
      end else if (slot_free) begin
        seq_in.valid <= 1'b0;
      end
    end
  end

  // Result monitor: checks each transfer against the oldest expectation and
  // drives ready with random stalls and one long hold.
  always @(posedge clk_i) begin : monitor_p
    sorted_elem_t want;
    int unsigned  pause;
    if (!rst_ni) begin
      sorted_out.ready <= 1'b0;
    end else if (sorted_out.valid && sorted_out.ready) begin
      if (expected_run.size() == 0) begin
        note_mismatch($sformatf("unexpected result value %0d final %0b",
                                sorted_out.sorted_value, sorted_out.is_final));
      end else begin
        want = expected_run.pop_front();
        if (sorted_out.sorted_value !== want.value || sorted_out.is_final !== want.is_final) begin
          note_mismatch($sformatf("result %0d: expected value %0d final %0b, got value %0d final %0b",
                                  results_seen, want.value, want.is_final,
                                  sorted_out.sorted_value, sorted_out.is_final));
        end
      end
      results_seen++;
      if (!hold_done && results_seen == HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        sorted_out.ready <= 1'b0;
      end else begin
        pause      = draw_wait(recv_quiet);
        recv_stall = pause;
        sorted_out.ready <= (pause == 0);
      end
    end else if (!sorted_out.ready) begin
      if (hold_left != 0) begin
        hold_left--;
      end else if (recv_stall != 0) begin
        recv_stall--;
      end else begin
        sorted_out.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (seq_in.valid && seq_in.ready) ||
        (sorted_out.valid && sorted_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus, reset release and end of run.
  initial begin
    int unsigned len;
    bit          mid_drain;
    mid_drain = 1'b0;

    // Directed: single element, two extremes, ties, corner values.
    add_item(MinVal, 1'b1);
    add_item(MaxVal, 1'b0);
    add_item(MinVal, 1'b1);
    add_item(32'sd5, 1'b0);
    add_item(-32'sd1, 1'b0);
    add_item(32'sd5, 1'b0);
    add_item(32'sd0, 1'b0);
    add_item(-32'sd1, 1'b1);
    add_item(32'sd0, 1'b0);
    add_item(-32'sd1, 1'b0);
    add_item(32'sd1, 1'b0);
    add_item(MaxVal, 1'b0);
    add_item(MinVal, 1'b0);
    add_item(VALUE_BITS'(32'h5555_5555), 1'b0);
    add_item(VALUE_BITS'(32'haaaa_aaaa), 1'b1);
    add_item(32'sd7, 1'b0);
    add_item(32'sd3, 1'b1);

    // Full store ending on the last flag, then a full store without it whose
    // two extra elements start a new sequence.
    add_sequence(DEPTH, ValFull, 1'b1);
    add_sequence(DEPTH + 2, ValNarrow, 1'b0);

    // Random sequences, mostly short, some around the store size.
    while (item_queue.size() < ItemTarget) begin
      if ($urandom_range(0, 11) == 0) begin
        len = $urandom_range(DEPTH - 2, DEPTH + 6);
      end else begin
        len = $urandom_range(1, 12);
      end
      add_sequence(len, val_style_e'($urandom_range(0, 2)),
                   !mid_drain && item_queue.size() > ItemTarget / 2);
      if (item_queue.size() > ItemTarget / 2) begin
        mid_drain = 1'b1;
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    do begin
      @(posedge clk_i);
    end while (item_queue.size() != 0 || seq_in.valid || expected_run.size() != 0);
    repeat (TailCycles) @(posedge clk_i);

    if (expected_run.size() != 0) begin
      note_mismatch($sformatf("%0d expected results never came", expected_run.size()));
    end
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
